// ===== hdl/f2h_pkg.sv =====
package f2h_pkg;

    // ASCII codes used by the formatter.
    localparam logic [6:0] CH_0     = 7'h30;
    localparam logic [6:0] CH_1     = 7'h31;
    localparam logic [6:0] CH_A     = 7'h61;
    localparam logic [6:0] CH_F     = 7'h66;
    localparam logic [6:0] CH_I     = 7'h69;
    localparam logic [6:0] CH_N     = 7'h6e;
    localparam logic [6:0] CH_P     = 7'h70;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_DOT   = 7'h2e;
    localparam logic [6:0] CH_PLUS  = 7'h2b;
    localparam logic [6:0] CH_MINUS = 7'h2d;

    localparam int unsigned NUM_SLOTS = 16;
    localparam logic [7:0]  EXP_BIAS  = 8'd127;
    localparam logic [7:0]  EXP_ALL1  = 8'hff;

    // Slot positions in the fixed text template.
    localparam int unsigned SL_SIGN  = 0;
    localparam int unsigned SL_ZERO  = 1;
    localparam int unsigned SL_X     = 2;
    localparam int unsigned SL_LEAD  = 3;
    localparam int unsigned SL_POINT = 4;
    localparam int unsigned SL_HEX   = 5;
    localparam int unsigned SL_P     = 11;
    localparam int unsigned SL_ESIGN = 12;
    localparam int unsigned SL_D2    = 13;
    localparam int unsigned SL_D1    = 14;
    localparam int unsigned SL_D0    = 15;

    typedef struct packed {
        logic        neg;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic        is_den;
        logic [7:0]  expf;
        logic [22:0] frac;
        logic [4:0]  lz;
    } f2h_dec_t;

    typedef struct packed {
        logic        neg;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic        eneg;
        logic [7:0]  mag;
        logic [22:0] frac;
    } f2h_norm_t;

    typedef struct packed {
        logic        neg;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic        eneg;
        logic [5:0]  hex_en;
        logic [23:0] hex;
        logic        en2;
        logic        en1;
        logic [3:0]  d2;
        logic [3:0]  d1;
        logic [3:0]  d0;
    } f2h_dig_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][6:0] chars;
        logic [NUM_SLOTS-1:0]      mask;
    } f2h_text_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10) begin
            c = CH_0 + {3'b000, nib};
        end else begin
            c = CH_A + {3'b000, nib - 4'd10};
        end
        return c;
    endfunction

    function automatic logic [6:0] dec_char(input logic [3:0] dig);
        return CH_0 + {3'b000, dig};
    endfunction

endpackage

// ===== hdl/float32_to_hex_float_text.sv =====
// Channel   Dir  Beat contents
// s_axis    in   tdata[31:0] = value_bits (IEEE binary32 pattern)
// m_axis    out  tdata[6:0] = char_code, tdata[7] = 0; tlast = last_char
//
// Each value passes four register stages (classify, normalise, digits, layout)
// and then a sixteen-slot character buffer that sends one character a beat.
// A value's text has 3 to 16 characters; the output channel sets the sustained
// rate. The first character is presented once the value has passed the layout
// stage and been loaded into the buffer. Reset (aresetn low, synchronous) clears
// every valid bit; a stall on m_axis holds all stages and loses nothing.
module float32_to_hex_float_text
    import f2h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero pad
    output logic        m_tlast
);

    f2h_norm_t norm_data;
    logic      norm_valid, norm_ready;
    f2h_text_t text_data;
    logic      text_valid, text_ready;
    logic [6:0] char_code;

    // Field split, classification and normalisation of denormals.
    f2h_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_bits   (s_tdata),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_data  (norm_data)
    );

    // Decimal exponent digits, trailing-zero trimming and template layout.
    f2h_text u_text (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_data   (norm_data),
        .out_valid (text_valid),
        .out_ready (text_ready),
        .out_data  (text_data)
    );

    // The buffer reloads on the beat that carries the final character, so
    // consecutive texts follow without a gap.
    f2h_serial u_serial (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (text_valid),
        .in_ready  (text_ready),
        .in_data   (text_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (char_code),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, char_code};

endmodule

// ===== hdl/f2h_norm.sv =====
module f2h_norm
    import f2h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output f2h_norm_t   out_data
);

    f2h_dec_t  a_reg, a_next;
    logic      a_valid_reg;
    f2h_norm_t b_reg, b_next;
    logic      b_valid_reg;
    logic      a_ready, b_ready;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Stage A: split the fields, classify and count leading zeros of the fraction.
    always_comb begin
        a_next.neg     = in_bits[31];
        a_next.expf    = in_bits[30:23];
        a_next.frac    = in_bits[22:0];
        a_next.is_nan  = (in_bits[30:23] == EXP_ALL1) && (in_bits[22:0] != '0);
        a_next.is_inf  = (in_bits[30:23] == EXP_ALL1) && (in_bits[22:0] == '0);
        a_next.is_zero = (in_bits[30:23] == '0) && (in_bits[22:0] == '0);
        a_next.is_den  = (in_bits[30:23] == '0) && (in_bits[22:0] != '0);
        a_next.lz      = '0;
        for (int i = 0; i < 23; i++) begin
            if (in_bits[i]) begin
                a_next.lz = 5'(22 - i);
            end
        end
    end

    // Stage B: unbiased exponent as sign and magnitude, denormals normalised.
    always_comb begin
        b_next.neg     = a_reg.neg;
        b_next.is_nan  = a_reg.is_nan;
        b_next.is_inf  = a_reg.is_inf;
        b_next.is_zero = a_reg.is_zero;
        b_next.frac    = a_reg.frac;
        b_next.eneg    = 1'b0;
        b_next.mag     = '0;
        if (a_reg.is_zero) begin
            b_next.eneg = 1'b0;
            b_next.mag  = '0;
        end else if (a_reg.is_den) begin
            b_next.eneg = 1'b1;
            b_next.mag  = EXP_BIAS + {3'b000, a_reg.lz};
            b_next.frac = a_reg.frac << ({1'b0, a_reg.lz} + 6'd1);
        end else if (a_reg.expf >= EXP_BIAS) begin
            b_next.eneg = 1'b0;
            b_next.mag  = a_reg.expf - EXP_BIAS;
        end else begin
            b_next.eneg = 1'b1;
            b_next.mag  = EXP_BIAS - a_reg.expf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_reg <= a_next;
        end
        if (b_ready && a_valid_reg) begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule

// ===== hdl/f2h_text.sv =====
module f2h_text
    import f2h_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  f2h_norm_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output f2h_text_t out_data
);

    f2h_dig_t  c_reg, c_next;
    logic      c_valid_reg;
    f2h_text_t d_reg, d_next;
    logic      d_valid_reg;
    logic      c_ready, d_ready;
    logic      hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    // Stage C: decimal digits of the exponent and the visible hex digits.
    // The tens digit of a value below 100 is (r * 205) >> 11.
    always_comb begin
        hund     = in_data.mag >= 8'd100;
        rem      = hund ? 7'(in_data.mag - 8'd100) : in_data.mag[6:0];
        prod     = 15'(rem) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 7'(tens) * 7'd10;

        c_next.neg     = in_data.neg;
        c_next.is_nan  = in_data.is_nan;
        c_next.is_inf  = in_data.is_inf;
        c_next.is_zero = in_data.is_zero;
        c_next.eneg    = in_data.eneg;
        c_next.hex     = {in_data.frac, 1'b0};
        c_next.en2     = hund;
        c_next.en1     = in_data.mag >= 8'd10;
        c_next.d2      = {3'b000, hund};
        c_next.d1      = tens;
        c_next.d0      = 4'(rem - tens_x10);
        // A digit shows when it or any less significant digit is nonzero.
        for (int i = 0; i < 6; i++) begin
            c_next.hex_en[i] = (c_next.hex & ((24'd1 << (4 * i + 4)) - 24'd1)) != '0;
        end
    end

    // Stage D: lay the text into the sixteen template slots with an enable mask.
    always_comb begin
        d_next.chars = '0;
        d_next.mask  = '0;
        if (c_reg.is_nan) begin
            d_next.chars[0] = CH_N;
            d_next.chars[1] = CH_A;
            d_next.chars[2] = CH_N;
            d_next.mask     = 16'h0007;
        end else if (c_reg.is_inf) begin
            d_next.chars[0] = CH_MINUS;
            d_next.chars[1] = CH_I;
            d_next.chars[2] = CH_N;
            d_next.chars[3] = CH_F;
            d_next.mask     = {12'h000, 3'b111, c_reg.neg};
        end else begin
            d_next.chars[SL_SIGN]  = CH_MINUS;
            d_next.chars[SL_ZERO]  = CH_0;
            d_next.chars[SL_X]     = CH_X;
            d_next.chars[SL_LEAD]  = c_reg.is_zero ? CH_0 : CH_1;
            d_next.chars[SL_POINT] = CH_DOT;
            for (int i = 0; i < 6; i++) begin
                d_next.chars[SL_HEX + 5 - i] = hex_char(c_reg.hex[4 * i +: 4]);
                d_next.mask[SL_HEX + 5 - i]  = c_reg.hex_en[i];
            end
            d_next.chars[SL_P]     = CH_P;
            d_next.chars[SL_ESIGN] = c_reg.eneg ? CH_MINUS : CH_PLUS;
            d_next.chars[SL_D2]    = dec_char(c_reg.d2);
            d_next.chars[SL_D1]    = dec_char(c_reg.d1);
            d_next.chars[SL_D0]    = dec_char(c_reg.d0);
            d_next.mask[SL_SIGN]   = c_reg.neg;
            d_next.mask[SL_ZERO]   = 1'b1;
            d_next.mask[SL_X]      = 1'b1;
            d_next.mask[SL_LEAD]   = 1'b1;
            d_next.mask[SL_POINT]  = c_reg.hex_en[5];
            d_next.mask[SL_P]      = 1'b1;
            d_next.mask[SL_ESIGN]  = 1'b1;
            d_next.mask[SL_D2]     = c_reg.en2;
            d_next.mask[SL_D1]     = c_reg.en1;
            d_next.mask[SL_D0]     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_ready) begin
                c_valid_reg <= in_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            c_reg <= c_next;
        end
        if (d_ready && c_valid_reg) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_reg;

endmodule

// ===== hdl/f2h_serial.sv =====
module f2h_serial
    import f2h_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  f2h_text_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_code,
    output logic       out_last
);

    logic [NUM_SLOTS-1:0][6:0] chars_reg;
    logic [NUM_SLOTS-1:0]      mask_reg, mask_next;
    logic [3:0]                idx;
    logic                      beat;

    // Lowest enabled slot is the next character.
    always_comb begin
        idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                idx = 4'(i);
            end
        end
    end

    assign out_valid = mask_reg != '0;
    assign out_code  = chars_reg[idx];
    assign out_last  = out_valid && ((mask_reg & (mask_reg - 16'd1)) == '0);
    assign beat      = out_valid && out_ready;
    assign in_ready  = !out_valid || (beat && out_last);

    always_comb begin
        mask_next = mask_reg;
        if (beat) begin
            mask_next = mask_reg & (mask_reg - 16'd1);
        end
        if (in_ready && in_valid) begin
            mask_next = in_data.mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            chars_reg <= in_data.chars;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

// One expected character of the formatted text, with its end-of-text flag.
typedef struct {
    logic [6:0] code;
    logic       last;
} text_char_t;

// Keeps the characters still owed by the block and checks each output beat
// against the oldest of them.
class hex_text_scoreboard;
    text_char_t expected_chars[$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
    endfunction

    function int unsigned pending();
        return expected_chars.size();
    endfunction

    // Works out the %a text of one binary32 pattern and queues it.
    function void note_value(input logic [31:0] bits);
        logic       sgn;
        logic [7:0] expf;
        logic [22:0] frac;
        logic [23:0] nibbles;
        logic [6:0] txt[$];
        int         exponent;
        int unsigned mag;
        int         keep;
        int         shift;
        string      digit_lut;
        text_char_t tc;

        digit_lut = "0123456789abcdef";
        sgn  = bits[31];
        expf = bits[30:23];
        frac = bits[22:0];

        if (expf == f2h_pkg::EXP_ALL1 && frac != '0) begin
            txt = {f2h_pkg::CH_N, f2h_pkg::CH_A, f2h_pkg::CH_N};
        end else if (expf == f2h_pkg::EXP_ALL1) begin
            if (sgn) txt.push_back(f2h_pkg::CH_MINUS);
            txt.push_back(f2h_pkg::CH_I);
            txt.push_back(f2h_pkg::CH_N);
            txt.push_back(f2h_pkg::CH_F);
        end else begin
            if (sgn) txt.push_back(f2h_pkg::CH_MINUS);
            txt.push_back(f2h_pkg::CH_0);
            txt.push_back(f2h_pkg::CH_X);
            if (expf == '0 && frac == '0) begin
                txt.push_back(f2h_pkg::CH_0);
                txt.push_back(f2h_pkg::CH_P);
                txt.push_back(f2h_pkg::CH_PLUS);
                txt.push_back(f2h_pkg::CH_0);
            end else begin
                if (expf == '0) begin
                    // Denormal: slide the top set bit into the hidden-one position.
                    shift = 0;
                    while (!frac[22]) begin
                        frac = frac << 1;
                        shift++;
                    end
                    frac = frac << 1;
                    exponent = -126 - (shift + 1);
                end else begin
                    exponent = int'(expf) - int'(f2h_pkg::EXP_BIAS);
                end
                txt.push_back(f2h_pkg::CH_1);
                nibbles = {frac, 1'b0};
                keep = 6;
                while (keep > 0 && nibbles[(6 - keep) * 4 +: 4] == 4'h0) keep--;
                if (keep > 0) begin
                    txt.push_back(f2h_pkg::CH_DOT);
                    for (int i = 5; i >= 6 - keep; i--) begin
                        txt.push_back(7'(digit_lut[nibbles[i * 4 +: 4]]));
                    end
                end
                txt.push_back(f2h_pkg::CH_P);
                if (exponent < 0) begin
                    txt.push_back(f2h_pkg::CH_MINUS);
                    mag = -exponent;
                end else begin
                    txt.push_back(f2h_pkg::CH_PLUS);
                    mag = exponent;
                end
                if (mag >= 100) txt.push_back(7'(f2h_pkg::CH_0 + mag / 100));
                if (mag >= 10) txt.push_back(7'(f2h_pkg::CH_0 + (mag / 10) % 10));
                txt.push_back(7'(f2h_pkg::CH_0 + mag % 10));
            end
        end

        foreach (txt[i]) begin
            tc.code = txt[i];
            tc.last = (i == txt.size() - 1);
            expected_chars.push_back(tc);
        end
    endfunction

    function void report(input string what, input text_char_t want,
                         input logic [6:0] got_code, input logic got_last);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                     $realtime, what, want.code, want.last, got_code, got_last);
        end
    endfunction

    function void check_char(input logic [7:0] tdata, input logic tlast);
        text_char_t want;
        if (expected_chars.size() == 0) begin
            want.code = 'x;
            want.last = 'x;
            report("character with nothing outstanding", want, tdata[6:0], tlast);
        end else begin
            want = expected_chars.pop_front();
            if (tdata[6:0] !== want.code || tlast !== want.last) begin
                report("character mismatch", want, tdata[6:0], tlast);
            end
        end
    endfunction
endclass

module tb_top;
    import f2h_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung.
    // The longest deliberate hold-off is HOLDOFF_CYCLES, so this leaves
    // a wide margin over any correct run.
    localparam int unsigned QUIET_LIMIT    = 4000;
    // Deliberate output hold-off used to fill the block and back-pressure it.
    localparam int unsigned HOLDOFF_CYCLES = 300;
    // Items per random phase; five phases plus the directed list give
    // roughly 370 values in all.
    localparam int unsigned PHASE_ITEMS    = 70;
    // Extra cycles run after the final drain to settle the tail.
    localparam int unsigned TAIL_CYCLES    = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value_bits
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [6:0] char_code, [7] zero pad
    logic        m_tlast;

    hex_text_scoreboard text_sb = new();

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    // Cycles of forced output hold-off still to run; the receiver process
    // counts this down itself.
    int unsigned holdoff_left  = 0;
    int unsigned quiet_cycles  = 0;

    float32_to_hex_float_text dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 20 ns clock: ten high, ten low.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver. Ready changes only on the falling edge so that the block
    // sees a settled value at the rising edge. A pending hold-off takes
    // priority over the random stall pattern.
    always @(negedge aclk) begin
        if (holdoff_left > 0) begin
            m_tready = 1'b0;
            holdoff_left--;
        end else begin
            m_tready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Output monitor: every accepted character goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) text_sb.check_char(m_tdata, m_tlast);
    end

    // Watchdog. Any beat on either side restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one value, idling first at the current sender rate. Entered and
    // left on a falling edge; the value is noted as soon as its beat is taken.
    task automatic send_value(input logic [31:0] bits);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = bits;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        text_sb.note_value(bits);
        @(negedge aclk);
    endtask

    // Sender stays quiet until every outstanding character has been seen.
    task automatic wait_for_drain();
        s_tvalid = 1'b0;
        while (text_sb.pending() != 0) @(negedge aclk);
    endtask

    // Random pattern biased towards the interesting corners: stripped
    // trailing digits, denormals, small exponents and the special encodings.
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        logic [22:0] fr;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        v = $urandom();
        if (pick < 35) begin
            // Leave the pattern fully random.
        end else if (pick < 60) begin
            // Normal value with only the top few hex digits populated.
            fr = v[22:0] & (23'h7fffff << (4 * $urandom_range(0, 5)));
            v = {v[31], 8'($urandom_range(1, 254)), fr};
        end else if (pick < 75) begin
            // Denormal with its top set bit anywhere in the fraction.
            fr = v[22:0] >> $urandom_range(0, 22);
            if (fr == '0) fr = 23'd1;
            v = {v[31], 8'h00, fr};
        end else if (pick < 85) begin
            // Exponent around zero: -10 to +10, so zero, one-digit and two-digit values.
            v[30:23] = 8'($urandom_range(117, 137));
        end else if (pick < 95) begin
            case ($urandom_range(0, 2))
                0: v[30:0] = '0;
                1: v[30:0] = {EXP_ALL1, 23'd0};
                default: begin
                    v[30:23] = EXP_ALL1;
                    if (v[22:0] == '0) v[0] = 1'b1;
                end
            endcase
        end else begin
            v[30:23] = ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd254;
        end
        return v;
    endfunction

    // Directed values: signed zeros, infinities, quiet NaNs of both signs, a
    // signalling NaN, the range extremes, the smallest and largest denormals,
    // zero exponent, one-, two- and three-digit exponents, and fractions
    // with zero, one, three, five and six surviving hex digits.
    logic [31:0] directed_values[] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
        32'h7fc0_0000, 32'hffff_ffff, 32'h7f80_0001, 32'h3f80_0000,
        32'hbf80_0000, 32'h7f7f_ffff, 32'hff7f_ffff, 32'h0080_0000,
        32'h0000_0001, 32'h8000_0001, 32'h007f_ffff, 32'h807f_ffff,
        32'h0040_0000, 32'h0000_0003, 32'h4120_0000, 32'h4b00_0000,
        32'h3c00_0000, 32'h3fc0_0000, 32'h3f80_0001, 32'h3f88_8800,
        32'h3fff_fff0
    };

    initial begin
        // Synchronous reset, held low from the start and released on a falling edge.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part with no idling on either side.
        foreach (directed_values[i]) send_value(directed_values[i]);
        wait_for_drain();

        // Random phases: unthrottled, slow sender, slow receiver, both
        // throttled lightly, and finally a long output hold-off while the
        // sender keeps pushing, which fills the pipeline and drops s_tready.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
                3: begin src_idle_pct = 25; sink_stall_pct = 25; end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    holdoff_left   = HOLDOFF_CYCLES;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_value(random_value());
            // Pause the sender until the block has emptied completely.
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (text_sb.mismatches == 0 && text_sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/f2h_pkg.sv
hdl/f2h_norm.sv
hdl/f2h_text.sv
hdl/f2h_serial.sv
hdl/float32_to_hex_float_text.sv
dv/tb_top.sv
